>>> rtl/core/qrv_pkg.sv
`timescale 1ns / 1ps
package qrv_pkg;

  localparam int VEC_WIDTH = 24;
  localparam int QUAT_WIDTH = 16;
  localparam int SQ_WIDTH = 2 * QUAT_WIDTH;
  localparam int NORM_WIDTH = SQ_WIDTH + 1;
  localparam int COEF_WIDTH = SQ_WIDTH + 2;
  localparam int PROD_WIDTH = COEF_WIDTH + VEC_WIDTH;
  localparam int SUM_WIDTH = PROD_WIDTH + 2;
  localparam int QUO_BITS = VEC_WIDTH + 2;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_QUAT_X = 3'd0,
    REG_QUAT_Y = 3'd1,
    REG_QUAT_Z = 3'd2,
    REG_QUAT_W = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        clipped;
    logic                        zero_rotation;
  } vec_out_t;

  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic [NORM_WIDTH-1:0] norm;
  } lane_ctl_t;

endpackage

>>> rtl/core/quaternion_rotate_vector.sv
`timescale 1ns / 1ps
// Rotates signed 3-vectors by the quaternion held in four config registers.
// Config: cfg_we writes cfg_data[15:0] to register cfg_index (0 x, 1 y, 2 z,
// 3 w); other indexes are ignored. Write only while no transaction is in
// flight. Reset loads the identity rotation (w = 16384, x = y = z = 0).
// Input: a transaction is taken on each clock edge with start high; busy is
// always low, so one vector per cycle is sustained.
// Output: done pulses for one cycle with result valid; results leave in
// order, one per input.
// The pipeline is two stages building the rotation matrix and norm, two
// stages of matrix-vector multiply and sum, then a restoring divider with an
// input register, one quotient bit per stage (VEC_WIDTH + 2 stages) and a
// round and saturate stage; the divider depth sets the latency.
// The receiver cannot stall; results are never held. Reset empties the
// pipeline and drops any transaction in flight.
module quaternion_rotate_vector import qrv_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  vec_in_t                     vec,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [QUAT_WIDTH-1:0]       cfg_data,
  output logic                        done,
  output vec_out_t                    result
);

  localparam int Latency = QUO_BITS + 6;

  logic signed [QUAT_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;

  lane_ctl_t                    coef_ctl;
  vec_in_t                      coef_vec;
  logic signed [COEF_WIDTH-1:0] coef [3][3];
  lane_ctl_t                    mul_ctl;
  logic                         mul_neg [3];
  logic [SUM_WIDTH-1:0]         mul_mag [3];
  logic                         div_valid;
  logic                         div_zero;
  logic [VEC_WIDTH-1:0]         div_value [3];
  logic                         div_clip [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_W_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        REG_QUAT_W: quat_w <= cfg_data;
        default: ;
      endcase
    end
  end

  qrv_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_vec   (vec),
    .qx       (quat_x),
    .qy       (quat_y),
    .qz       (quat_z),
    .qw       (quat_w),
    .ctl      (coef_ctl),
    .vec      (coef_vec),
    .coef     (coef)
  );

  qrv_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (coef_ctl),
    .in_vec (coef_vec),
    .coef   (coef),
    .ctl    (mul_ctl),
    .neg    (mul_neg),
    .mag    (mul_mag)
  );

  qrv_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (mul_ctl),
    .in_neg    (mul_neg[0]),
    .in_mag    (mul_mag[0]),
    .out_valid (div_valid),
    .out_zero  (div_zero),
    .out_value (div_value[0]),
    .out_clip  (div_clip[0])
  );

  qrv_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (mul_ctl),
    .in_neg    (mul_neg[1]),
    .in_mag    (mul_mag[1]),
    .out_valid (),
    .out_zero  (),
    .out_value (div_value[1]),
    .out_clip  (div_clip[1])
  );

  qrv_div u_div_z (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (mul_ctl),
    .in_neg    (mul_neg[2]),
    .in_mag    (mul_mag[2]),
    .out_valid (),
    .out_zero  (),
    .out_value (div_value[2]),
    .out_clip  (div_clip[2])
  );

  assign done                 = div_valid;
  assign result.rot_x         = div_zero ? '0 : div_value[0];
  assign result.rot_y         = div_zero ? '0 : div_value[1];
  assign result.rot_z         = div_zero ? '0 : div_value[2];
  assign result.clipped       = !div_zero && (div_clip[0] || div_clip[1] || div_clip[2]);
  assign result.zero_rotation = div_zero;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("accepted transaction did not complete on time");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_rotation) |->
      (result.rot_x == '0 && result.rot_y == '0 && result.rot_z == '0 && !result.clipped))
    else $error("zero rotation result not cleared");

  a_reset_identity: assert property (@(posedge clk)
    rst |=> (quat_w == QUAT_W_RESET && quat_x == '0 && !done))
    else $error("reset state wrong");

endmodule

>>> rtl/core/qrv_coef.sv
`timescale 1ns / 1ps
module qrv_coef import qrv_pkg::*; (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  vec_in_t                            in_vec,
  input  logic signed [QUAT_WIDTH-1:0]       qx,
  input  logic signed [QUAT_WIDTH-1:0]       qy,
  input  logic signed [QUAT_WIDTH-1:0]       qz,
  input  logic signed [QUAT_WIDTH-1:0]       qw,
  output lane_ctl_t                          ctl,
  output vec_in_t                            vec,
  output logic signed [COEF_WIDTH-1:0]       coef [3][3]
);

  logic                        s1_valid;
  vec_in_t                     s1_vec;
  logic signed [SQ_WIDTH-1:0]  xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  logic signed [COEF_WIDTH-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
  logic [NORM_WIDTH-1:0]       norm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      ctl.valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      ctl.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_vec <= in_vec;
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    ww <= qw * qw;
    xy <= qx * qy;
    xz <= qx * qz;
    yz <= qy * qz;
    wx <= qw * qx;
    wy <= qw * qy;
    wz <= qw * qz;
  end

  assign exx = COEF_WIDTH'(xx);
  assign eyy = COEF_WIDTH'(yy);
  assign ezz = COEF_WIDTH'(zz);
  assign eww = COEF_WIDTH'(ww);
  assign exy = COEF_WIDTH'(xy);
  assign exz = COEF_WIDTH'(xz);
  assign eyz = COEF_WIDTH'(yz);
  assign ewx = COEF_WIDTH'(wx);
  assign ewy = COEF_WIDTH'(wy);
  assign ewz = COEF_WIDTH'(wz);

  assign norm_next = NORM_WIDTH'(unsigned'(xx)) + NORM_WIDTH'(unsigned'(yy))
                   + NORM_WIDTH'(unsigned'(zz)) + NORM_WIDTH'(unsigned'(ww));

  always_ff @(posedge clk) begin
    vec        <= s1_vec;
    ctl.norm   <= norm_next;
    ctl.zero   <= (norm_next == '0);
    coef[0][0] <= eww + exx - eyy - ezz;
    coef[0][1] <= (exy - ewz) <<< 1;
    coef[0][2] <= (exz + ewy) <<< 1;
    coef[1][0] <= (exy + ewz) <<< 1;
    coef[1][1] <= eww - exx + eyy - ezz;
    coef[1][2] <= (eyz - ewx) <<< 1;
    coef[2][0] <= (exz - ewy) <<< 1;
    coef[2][1] <= (eyz + ewx) <<< 1;
    coef[2][2] <= eww - exx - eyy + ezz;
  end

endmodule

>>> rtl/core/qrv_mul.sv
`timescale 1ns / 1ps
module qrv_mul import qrv_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     in_ctl,
  input  vec_in_t                       in_vec,
  input  logic signed [COEF_WIDTH-1:0]  coef [3][3],
  output lane_ctl_t                     ctl,
  output logic                          neg [3],
  output logic [SUM_WIDTH-1:0]          mag [3]
);

  lane_ctl_t                    s3_ctl;
  logic signed [VEC_WIDTH-1:0]  v [3];
  logic signed [PROD_WIDTH-1:0] prod [3][3];
  logic signed [SUM_WIDTH-1:0]  sum [3];

  assign v[0] = in_vec.vec_x;
  assign v[1] = in_vec.vec_y;
  assign v[2] = in_vec.vec_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid <= 1'b0;
      ctl.valid    <= 1'b0;
    end else begin
      s3_ctl.valid <= in_ctl.valid;
      ctl.valid    <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_ctl.zero <= in_ctl.zero;
    s3_ctl.norm <= in_ctl.norm;
    ctl.zero    <= s3_ctl.zero;
    ctl.norm    <= s3_ctl.norm;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod[k][j] <= coef[k][j] * v[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_WIDTH'(prod[k][0]) + SUM_WIDTH'(prod[k][1]) + SUM_WIDTH'(prod[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      neg[k] <= sum[k][SUM_WIDTH-1];
      mag[k] <= sum[k][SUM_WIDTH-1] ? unsigned'(-sum[k]) : unsigned'(sum[k]);
    end
  end

endmodule

>>> rtl/core/qrv_div.sv
`timescale 1ns / 1ps
module qrv_div import qrv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  lane_ctl_t             in_ctl,
  input  logic                  in_neg,
  input  logic [SUM_WIDTH-1:0]  in_mag,
  output logic                  out_valid,
  output logic                  out_zero,
  output logic [VEC_WIDTH-1:0]  out_value,
  output logic                  out_clip
);

  localparam logic [QUO_BITS:0] POS_LIM = (QUO_BITS+1)'((1 << (VEC_WIDTH - 1)) - 1);
  localparam logic [QUO_BITS:0] NEG_LIM = (QUO_BITS+1)'(1 << (VEC_WIDTH - 1));

  logic                  vld  [QUO_BITS+1];
  logic                  sgn  [QUO_BITS+1];
  logic                  zro  [QUO_BITS+1];
  logic [NORM_WIDTH-1:0] den  [QUO_BITS+1];
  logic [SUM_WIDTH-1:0]  rem  [QUO_BITS+1];
  logic [QUO_BITS-1:0]   quo  [QUO_BITS+1];

  logic                  round_up;
  logic [QUO_BITS:0]     rounded;
  logic [QUO_BITS:0]     lim;
  logic                  sat;
  logic [VEC_WIDTH-1:0]  mag_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0]    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld[0]    <= in_ctl.valid;
      out_valid <= vld[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    sgn[0] <= in_neg;
    zro[0] <= in_ctl.zero;
    den[0] <= in_ctl.norm;
    rem[0] <= in_mag;
    quo[0] <= '0;
  end

  for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
    localparam int Shift = QUO_BITS - 1 - s;
    logic [SUM_WIDTH-1:0] trial;
    logic                 fits;

    assign trial = SUM_WIDTH'(den[s]) << Shift;
    assign fits  = (rem[s] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      sgn[s+1] <= sgn[s];
      zro[s+1] <= zro[s];
      den[s+1] <= den[s];
      rem[s+1] <= fits ? rem[s] - trial : rem[s];
      quo[s+1] <= {quo[s][QUO_BITS-2:0], fits};
    end
  end

  assign round_up = ({rem[QUO_BITS][NORM_WIDTH-1:0], 1'b0} >= {1'b0, den[QUO_BITS]});
  assign rounded  = {1'b0, quo[QUO_BITS]} + (QUO_BITS+1)'(round_up);
  assign lim      = sgn[QUO_BITS] ? NEG_LIM : POS_LIM;
  assign sat      = (rounded > lim);
  assign mag_out  = sat ? lim[VEC_WIDTH-1:0] : rounded[VEC_WIDTH-1:0];

  always_ff @(posedge clk) begin
    out_zero  <= zro[QUO_BITS];
    out_clip  <= sat;
    out_value <= sgn[QUO_BITS] ? -mag_out : mag_out;
  end

endmodule
